### hdl/u8san_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8san_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int MAX_BYTES       = 4;
	localparam int IDX_W           = $clog2(MAX_BYTES);
	localparam int CNT_W           = $clog2(MAX_BYTES + 1);

	localparam logic [7:0] REPL_RESET = 8'h3F;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MIN  = 8'hC0;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] PASS_MIN   = 8'hF8;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      last;
	} rec_t;

endpackage

`default_nettype wire

### hdl/u8san_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8san_front
	import u8san_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       q_full,
	output logic            push,
	output rec_t            push_rec
);

	logic [7:0] repl_q;
	logic       pending_q;
	logic [7:0] lead_q;
	logic [1:0] need_q;
	logic [1:0] held_q;
	logic [1:0][7:0] hold_q;

	logic       acc;
	logic       cont;
	logic [1:0] need_new;
	logic [1:0] held_inc;
	logic [7:0] fb;
	logic       fcnt;
	logic       open;
	logic [CNT_W-1:0] nrep;
	logic       wr_hold;
	logic       pending_d;
	logic [1:0] need_d;
	logic [1:0] held_d;
	rec_t       rec;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		cont     = (in_byte & CONT_MASK) == CONT_TAG;
		need_new = (in_byte < LEAD3_MIN) ? 2'd1 : (in_byte < LEAD4_MIN) ? 2'd2 : 2'd3;
		held_inc = held_q + 2'd1;
		fb   = in_byte;
		fcnt = 1'b1;
		open = 1'b0;
		if (in_byte < CONT_TAG || in_byte >= PASS_MIN) begin
			fb = in_byte;
		end else if (in_byte < LEAD2_MIN) begin
			fb = repl_q;
		end else if (in_last) begin
			fb = repl_q;
		end else begin
			fcnt = 1'b0;
			open = 1'b1;
		end

		rec       = '0;
		rec.last  = in_last;
		nrep      = '0;
		wr_hold   = 1'b0;
		pending_d = pending_q;
		need_d    = need_q;
		held_d    = held_q;

		if (pending_q && cont) begin
			if (held_inc >= need_q) begin
				rec.bytes[0] = lead_q;
				rec.bytes[1] = (held_q != 2'd0) ? hold_q[0] : in_byte;
				rec.bytes[2] = (held_q == 2'd2) ? hold_q[1] : in_byte;
				rec.bytes[3] = in_byte;
				rec.cnt      = CNT_W'(held_q) + CNT_W'(2);
				pending_d    = 1'b0;
				need_d       = 2'd0;
				held_d       = 2'd0;
			end else begin
				wr_hold = 1'b1;
				held_d  = held_inc;
				if (in_last) begin
					for (int i = 0; i < MAX_BYTES; i++) begin
						rec.bytes[i] = repl_q;
					end
					rec.cnt   = CNT_W'(held_inc) + CNT_W'(1);
					pending_d = 1'b0;
					need_d    = 2'd0;
					held_d    = 2'd0;
				end
			end
		end else begin
			if (pending_q) begin
				nrep = CNT_W'(held_q) + CNT_W'(1);
			end
			for (int i = 0; i < MAX_BYTES; i++) begin
				rec.bytes[i] = (CNT_W'(i) < nrep) ? repl_q : fb;
			end
			rec.cnt   = nrep + CNT_W'(fcnt);
			pending_d = open;
			need_d    = open ? need_new : 2'd0;
			held_d    = 2'd0;
		end
	end

	assign push     = acc && (rec.cnt != '0);
	assign push_rec = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q    <= REPL_RESET;
			pending_q <= 1'b0;
			lead_q    <= 8'h00;
			need_q    <= 2'd0;
			held_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				repl_q <= cfg_wdata;
			end
			if (acc) begin
				pending_q <= pending_d;
				need_q    <= need_d;
				held_q    <= held_d;
				if (open && !(pending_q && cont)) begin
					lead_q <= in_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && wr_hold) begin
			hold_q[held_q[0]] <= in_byte;
		end
	end

endmodule

`default_nettype wire

### hdl/u8san_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u8san_queue
	import u8san_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t push_rec,
	input  wire logic pop,
	output rec_t      head,
	output logic      empty,
	output logic      full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == CW'(DEPTH);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_rec;
		end
	end

endmodule

`default_nettype wire

### hdl/u8san_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8san_back
	import u8san_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rec_t head,
	input  wire logic empty,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [7:0] out_byte,
	output logic      out_last
);

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic [IDX_W-1:0] idx_q;

	logic adv;
	logic load;
	logic at_end;

	assign adv    = !out_valid_q || out_ready;
	assign load   = adv && !empty;
	assign at_end = idx_q == IDX_W'(head.cnt - CNT_W'(1));
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= !empty;
			end
			if (load) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.bytes[idx_q];
			out_last_q <= head.last && at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

### hdl/utf8_stream_sanitizer.sv
// Channel  | Handshake            | Payload
// in       | in_valid / in_ready  | in_byte[7:0], in_last
// out      | out_valid / out_ready| out_byte[7:0], out_last
// cfg      | cfg_we               | cfg_wdata[7:0] (replacement byte)
//
// Input takes one byte per cycle while the record queue has room.
// Each input byte yields 0 to 4 output bytes; if any, they enter the queue
// as one record. The output stage sends one byte per cycle while out_ready
// allows it, and pops a record when it loads the record's last byte. A
// byte is written to a queue slot, then loaded into the output register behind out_valid.
// in_ready drops when QUEUE_DEPTH records wait; reset empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_sanitizer
	import u8san_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic push;
	rec_t push_rec;
	logic pop;
	rec_t head;
	logic empty;
	logic full;

	u8san_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (full),
		.push     (push),
		.push_rec (push_rec)
	);

	u8san_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	u8san_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule

`default_nettype wire

### hdl/u8san_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u8san_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] in_byte,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	logic [7:0] lasts_q;
	logic       in_end;
	logic       out_end;

	assign in_end  = in_valid && in_ready && in_last;
	assign out_end = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lasts_q <= 8'd0;
		end else if (in_end && !out_end) begin
			lasts_q <= lasts_q + 8'd1;
		end else if (out_end && !in_end) begin
			lasts_q <= lasts_q - 8'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output changed while stalled");

	a_last_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_end |-> lasts_q != 8'd0)
		else $error("end-of-string output without matching input");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

	a_first_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind utf8_stream_sanitizer u8san_checker u_chk (.*);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import u8san_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	byte_item_t raw_bytes[$];
	byte_item_t expected_bytes[$];
	byte_item_t next_raw;
	byte_item_t want;

	logic [7:0] replacement = REPL_RESET;
	logic       seq_open = 1'b0;
	logic [7:0] seq_lead = 8'h00;
	logic [1:0] seq_need = 2'd0;
	logic [1:0] seq_held = 2'd0;
	logic [7:0] seq_bytes[2];

	int mismatches = 0;
	int send_idle_pct = 15;
	int recv_idle_pct = 15;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	utf8_stream_sanitizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic sanitize_byte(input logic [7:0] b, input logic last);
		logic [7:0] res[$];
		bit         fresh;
		bit         cont;
		int         k;
		fresh = 1'b1;
		cont = (b & CONT_MASK) == CONT_TAG;
		if (seq_open) begin
			if (cont) begin
				fresh = 1'b0;
				if (int'(seq_held) + 1 >= int'(seq_need)) begin
					res.push_back(seq_lead);
					for (k = 0; k < int'(seq_held); k++)
						res.push_back(seq_bytes[k]);
					res.push_back(b);
					seq_open = 1'b0;
					seq_held = 2'd0;
					seq_need = 2'd0;
				end else begin
					seq_bytes[seq_held[0]] = b;
					seq_held = seq_held + 2'd1;
					if (last) begin
						for (k = 0; k <= int'(seq_held); k++)
							res.push_back(replacement);
						seq_open = 1'b0;
						seq_held = 2'd0;
						seq_need = 2'd0;
					end
				end
			end else begin
				for (k = 0; k <= int'(seq_held); k++)
					res.push_back(replacement);
				seq_open = 1'b0;
				seq_held = 2'd0;
				seq_need = 2'd0;
			end
		end
		if (fresh) begin
			if (b < CONT_TAG || b >= PASS_MIN) begin
				res.push_back(b);
			end else if (b < LEAD2_MIN || last) begin
				res.push_back(replacement);
			end else begin
				seq_open = 1'b1;
				seq_lead = b;
				seq_held = 2'd0;
				seq_need = (b < LEAD3_MIN) ? 2'd1 : (b < LEAD4_MIN) ? 2'd2 : 2'd3;
			end
		end
		for (k = 0; k < res.size(); k++)
			expected_bytes.push_back('{data: res[k], last: last && (k == res.size() - 1)});
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				sanitize_byte(in_byte, in_last);
			if (!in_valid || in_ready) begin
				if (raw_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_raw = raw_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= next_raw.data;
					in_last <= next_raw.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected transfer: out_byte=%h out_last=%b", out_byte, out_last);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, out_byte);
						mismatches++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, out_last);
						mismatches++;
					end
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("** utf8_stream_sanitizer: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_raw(input logic [7:0] b, input logic last);
		raw_bytes.push_back('{data: b, last: last});
	endtask

	task automatic wait_drained;
		do @(negedge clk);
		while (raw_bytes.size() != 0 || in_valid || expected_bytes.size() != 0);
	endtask

	task automatic set_replacement(input logic [7:0] value);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		replacement = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random_text(input int count);
		int         n;
		int         kind;
		int         len;
		int         cut;
		int         k;
		logic [7:0] b;
		logic       last;
		n = 0;
		while (n < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				len = $urandom_range(1, 4);
				case (len)
					1: b = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8'h7F))
						: 8'($urandom_range(8'hF8, 8'hFF));
					2: b = 8'($urandom_range(8'hC0, 8'hDF));
					3: b = 8'($urandom_range(8'hE0, 8'hEF));
					default: b = 8'($urandom_range(8'hF0, 8'hF7));
				endcase
				cut = len;
				if (kind >= 50 && len > 1)
					cut = $urandom_range(1, len - 1);
				for (k = 0; k < cut; k++) begin
					if (k > 0)
						b = 8'($urandom_range(8'h80, 8'hBF));
					last = 1'b0;
					if (k == cut - 1)
						last = (cut < len) ? 1'($urandom_range(0, 1))
							: ($urandom_range(0, 5) == 0);
					push_raw(b, last);
					n++;
				end
			end else if (kind < 80) begin
				push_raw(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 5) == 0);
				n++;
			end else begin
				push_raw(8'($urandom), $urandom_range(0, 3) == 0);
				n++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_raw(8'h00, 1'b0);
		push_raw(8'h7F, 1'b1);
		push_raw(8'hFF, 1'b0);
		push_raw(8'hF8, 1'b0);
		push_raw(8'h80, 1'b0);
		push_raw(8'hC3, 1'b0);
		push_raw(8'hA9, 1'b0);
		push_raw(8'hE2, 1'b0);
		push_raw(8'h82, 1'b0);
		push_raw(8'hAC, 1'b0);
		push_raw(8'hF0, 1'b0);
		push_raw(8'h9F, 1'b0);
		push_raw(8'h98, 1'b0);
		push_raw(8'h80, 1'b1);
		push_raw(8'hC3, 1'b0);
		push_raw(8'h41, 1'b0);
		push_raw(8'hE2, 1'b0);
		push_raw(8'h82, 1'b0);
		push_raw(8'h41, 1'b0);
		push_raw(8'hE2, 1'b0);
		push_raw(8'h82, 1'b1);
		push_raw(8'hF0, 1'b0);
		push_raw(8'h90, 1'b0);
		push_raw(8'h80, 1'b1);
		push_raw(8'hC5, 1'b1);
		wait_drained();

		set_replacement(8'h00);
		queue_random_text(PHASE_ITEMS);
		wait_drained();

		set_replacement(8'hFF);
		queue_random_text(PHASE_ITEMS);
		hold_req++;
		wait_drained();

		set_replacement(8'($urandom));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_text(PHASE_ITEMS);
		wait_drained();

		set_replacement(REPL_RESET);
		send_idle_pct = 15;
		recv_idle_pct = 15;
		queue_random_text(PHASE_ITEMS);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** utf8_stream_sanitizer: PASSED **");
		else
			$display("** utf8_stream_sanitizer: FAILED **");
		$finish;
	end

endmodule
